// File: sv/csr_spmv_pkg.sv
// Package for the compressed-sparse-row matrix engine.
// Holds the op codes and the input and result word types; no dependencies.
package csr_spmv_pkg;

  localparam logic [2:0] OP_ROW_PTR  = 3'd0;
  localparam logic [2:0] OP_ENTRY    = 3'd1;
  localparam logic [2:0] OP_VECTOR   = 3'd2;
  localparam logic [2:0] OP_MULTIPLY = 3'd3;
  localparam logic [2:0] OP_GET      = 3'd4;

  localparam logic [6:0] ROW_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic [2:0]         op;
    logic [9:0]         slot;
    logic [6:0]         row;
    logic [5:0]         column;
    logic signed [31:0] value;
    logic [10:0]        pointer;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         out_row;
    logic signed [63:0] sum;
    logic               last;
  } out_word_t;

endpackage

// File: sv/csr_spmv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for every store of the sparse matrix engine; no dependencies.
module csr_spmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/csr_sparse_matrix_vector_multiply_top.sv
// Top level of the compressed-sparse-row matrix engine: loads, multiply, get.
// Depends on csr_spmv_pkg and three csr_spmv_ram instances.
//
//   channel  | ports                          | word
//   ---------+--------------------------------+------------
//   input    | in_valid, in_stall, in_word    | in_word_t
//   result   | out_valid, out_stall, out_word | out_word_t
//   config   | cfg_we, cfg_wdata              | row_count
//
// Load words follow back to back while the engine is idle.
// The entry memory's single read port walks one entry a cycle.
// Synchronous active-low reset clears control only; stores start undefined.
// Result stall holds the walk at the end of a row until the previous result word is taken.
module csr_sparse_matrix_vector_multiply_top
  import csr_spmv_pkg::*;
#(
  parameter int MAX_ROWS     = 64,
  parameter int MAX_NONZEROS = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);

  localparam int RAW = $clog2(MAX_ROWS + 1);
  localparam int VAW = $clog2(MAX_ROWS);
  localparam int NAW = $clog2(MAX_NONZEROS);
  localparam int PW  = ($clog2(MAX_NONZEROS + 1) > 11) ? $clog2(MAX_NONZEROS + 1) : 11;
  localparam int EW  = 6 + 32;

  typedef enum logic [2:0] {S_IDLE, S_LO, S_HI, S_WALK, S_EMIT} state_t;

  state_t             state_r;
  logic [6:0]         row_count_r;
  logic               mode_get_r;
  logic [RAW-1:0]     cur_row_r;
  logic [5:0]         get_row_r;
  logic [5:0]         get_col_r;
  logic [PW-1:0]      lo_r;
  logic [PW-1:0]      hi_r;
  logic [PW-1:0]      k_r;
  logic               v1_r;
  logic               v2_r;
  logic               v3_r;
  logic signed [31:0] val2_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;
  logic               out_valid_r;
  out_word_t          out_word_r;

  logic               in_acc;
  logic [6:0]         n_eff;
  logic               rs_we;
  logic [RAW-1:0]     rs_waddr;
  logic               rs_re;
  logic [RAW-1:0]     rs_raddr;
  logic [10:0]        rs_rdata;
  logic               en_we;
  logic               en_re;
  logic [EW-1:0]      en_rdata;
  logic               vs_we;
  logic               vs_re;
  logic [VAW-1:0]     vs_raddr;
  logic [31:0]        vs_rdata;
  logic [5:0]         en_col;
  logic signed [31:0] en_val;
  logic               issue;
  logic               walk_done;
  logic               out_free;
  logic               more_rows;
  logic [RAW-1:0]     cur_row_nxt;

  function automatic logic [PW-1:0] clamp_ptr(input logic [10:0] p);
    logic [PW-1:0] w;
    w = PW'(p);
    if (32'(w) > MAX_NONZEROS) begin
      w = PW'(MAX_NONZEROS);
    end
    return w;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  assign in_stall    = (state_r != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign n_eff       = (32'(row_count_r) > MAX_ROWS) ? 7'(MAX_ROWS) : row_count_r;
  assign en_col      = en_rdata[EW-1:32];
  assign en_val      = $signed(en_rdata[31:0]);
  assign issue       = (state_r == S_WALK) && (k_r < hi_r);
  assign walk_done   = (state_r == S_WALK) && !(k_r < hi_r) && !v1_r && !v2_r && !v3_r;
  assign out_free    = !out_valid_r || !out_stall;
  assign cur_row_nxt = RAW'(cur_row_r + 1'b1);
  assign more_rows   = !mode_get_r && ((7'(cur_row_r) + 7'd1) < n_eff);

  assign rs_we    = in_acc && in_word.op == OP_ROW_PTR && 32'(in_word.row) <= MAX_ROWS;
  assign rs_waddr = RAW'(in_word.row);
  assign en_we    = in_acc && in_word.op == OP_ENTRY && 32'(in_word.slot) < MAX_NONZEROS;
  assign vs_we    = in_acc && in_word.op == OP_VECTOR && 32'(in_word.column) < MAX_ROWS;
  assign en_re    = issue;
  assign vs_re    = v1_r && !mode_get_r && 32'(en_col) < MAX_ROWS;
  assign vs_raddr = VAW'(en_col);

  always_comb begin
    rs_re    = 1'b0;
    rs_raddr = cur_row_nxt;
    unique case (state_r)
      S_IDLE: begin
        rs_raddr = (in_word.op == OP_GET) ? RAW'(in_word.row) : '0;
        rs_re    = in_acc && ((in_word.op == OP_MULTIPLY && n_eff != 7'd0) ||
                              (in_word.op == OP_GET && 32'(in_word.row) < MAX_ROWS));
      end
      S_LO: begin
        rs_re = 1'b1;
      end
      S_EMIT: begin
        rs_raddr = RAW'(cur_row_nxt + 1'b1);
        rs_re    = out_free && more_rows;
      end
      default: begin
        rs_re = 1'b0;
      end
    endcase
  end

  csr_spmv_ram #(.WIDTH(11), .DEPTH(MAX_ROWS + 1)) u_row_start (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (in_word.pointer),
    .re    (rs_re),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  csr_spmv_ram #(.WIDTH(EW), .DEPTH(MAX_NONZEROS)) u_entry (
    .clk   (clk),
    .we    (en_we),
    .waddr (NAW'(in_word.slot)),
    .wdata ({in_word.column, in_word.value}),
    .re    (en_re),
    .raddr (k_r[NAW-1:0]),
    .rdata (en_rdata)
  );

  csr_spmv_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_vector (
    .clk   (clk),
    .we    (vs_we),
    .waddr (VAW'(in_word.column)),
    .wdata (in_word.value),
    .re    (vs_re),
    .raddr (vs_raddr),
    .rdata (vs_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_count_r <= ROW_COUNT_RESET;
      mode_get_r  <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_count_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      v1_r <= issue;
      v2_r <= vs_re;
      v3_r <= v2_r;
      if (issue) begin
        k_r <= PW'(k_r + 1'b1);
      end
      if (vs_re) begin
        val2_r <= en_val;
      end
      if (v2_r) begin
        prod_r <= val2_r * $signed(vs_rdata);
      end
      if (v3_r) begin
        acc_r <= sat_add(acc_r, prod_r);
      end
      if (v1_r && mode_get_r && en_col == get_col_r) begin
        acc_r <= {{16{en_val[31]}}, en_val, 16'd0};
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_word.op == OP_MULTIPLY && n_eff != 7'd0) begin
            mode_get_r <= 1'b0;
            cur_row_r  <= '0;
            state_r    <= S_LO;
          end else if (in_acc && in_word.op == OP_GET) begin
            mode_get_r <= 1'b1;
            get_row_r  <= in_word.row[5:0];
            get_col_r  <= in_word.column;
            cur_row_r  <= RAW'(in_word.row);
            acc_r      <= '0;
            if (32'(in_word.row) < MAX_ROWS) begin
              state_r <= S_LO;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_LO: begin
          lo_r    <= clamp_ptr(rs_rdata);
          state_r <= S_HI;
        end
        S_HI: begin
          hi_r    <= clamp_ptr(rs_rdata);
          k_r     <= lo_r;
          acc_r   <= '0;
          state_r <= S_WALK;
        end
        S_WALK: begin
          if (walk_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r        <= 1'b1;
            out_word_r.out_row <= mode_get_r ? get_row_r : 6'(cur_row_r);
            out_word_r.sum     <= acc_r;
            out_word_r.last    <= !more_rows;
            if (more_rows) begin
              cur_row_r <= cur_row_nxt;
              lo_r      <= hi_r;
              state_r   <= S_HI;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: verif/csr_sparse_matrix_vector_multiply_top_tb.sv
`timescale 1ns / 1ps
// Testbench for csr_sparse_matrix_vector_multiply_top: directed and random CSR load,
// multiply and get words, checked against an in-bench matrix model with saturating sums.
// Depends on csr_spmv_pkg and the engine's top level only.
module csr_sparse_matrix_vector_multiply_top_tb;
  import csr_spmv_pkg::*;

  localparam int N_ROWS        = 64;
  localparam int N_SLOTS       = 1024;
  localparam int GAP_MAX       = 18;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 250;
  localparam int STALL_LIMIT   = 5000;
  localparam int ITEM_TARGET   = 300;
  localparam logic [2:0] OP_FIRST_UNUSED = OP_GET + 3'd1;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_word;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  logic [10:0]        row_ptr  [0:N_ROWS];
  logic [5:0]         ent_col  [0:N_SLOTS-1];
  logic signed [31:0] ent_val  [0:N_SLOTS-1];
  logic signed [31:0] vec_elem [0:N_ROWS-1];
  bit                 ptr_known [0:N_ROWS];
  bit                 ent_known [0:N_SLOTS-1];
  bit                 vec_known [0:N_ROWS-1];
  logic [6:0]         rows_cfg;
  out_word_t          pending_sums [$];

  int errors;
  int items_sent;
  int quiet_cycles;
  bit calm;
  bit hold_req;

  csr_sparse_matrix_vector_multiply_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_ptr(input logic [10:0] p);
    return (p > N_SLOTS) ? N_SLOTS : int'(p);
  endfunction

  function automatic int active_rows();
    return (rows_cfg > N_ROWS) ? N_ROWS : int'(rows_cfg);
  endfunction

  function automatic bit row_readable(input int r, input bit with_vector);
    int lo;
    int hi;
    if (!ptr_known[r] || !ptr_known[r + 1]) return 1'b0;
    lo = clamp_ptr(row_ptr[r]);
    hi = clamp_ptr(row_ptr[r + 1]);
    for (int k = lo; k < hi; k++)
      if (!ent_known[k] || (with_vector && !vec_known[ent_col[k]])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void csr_apply(input in_word_t w);
    longint             acc;
    longint             prod;
    logic signed [64:0] wide;
    int                 n;
    int                 lo;
    int                 hi;
    out_word_t          res;
    case (w.op)
      OP_ROW_PTR: begin
        if (w.row <= N_ROWS) begin
          row_ptr[w.row]   = w.pointer;
          ptr_known[w.row] = 1'b1;
        end
      end
      OP_ENTRY: begin
        ent_col[w.slot]   = w.column;
        ent_val[w.slot]   = w.value;
        ent_known[w.slot] = 1'b1;
      end
      OP_VECTOR: begin
        vec_elem[w.column]  = w.value;
        vec_known[w.column] = 1'b1;
      end
      OP_MULTIPLY: begin
        n = active_rows();
        for (int r = 0; r < n; r++) begin
          acc = 0;
          lo  = clamp_ptr(row_ptr[r]);
          hi  = clamp_ptr(row_ptr[r + 1]);
          for (int k = lo; k < hi; k++) begin
            prod = longint'(ent_val[k]) * longint'(vec_elem[ent_col[k]]);
            wide = {acc[63], acc} + {prod[63], prod};
            if (wide[64] != wide[63]) acc = wide[64] ? SUM_MIN : SUM_MAX;
            else acc = wide[63:0];
          end
          res.out_row = r[5:0];
          res.sum     = acc;
          res.last    = (r == n - 1);
          pending_sums.push_back(res);
        end
      end
      OP_GET: begin
        acc = 0;
        if (w.row < N_ROWS) begin
          lo = clamp_ptr(row_ptr[w.row]);
          hi = clamp_ptr(row_ptr[w.row + 1]);
          for (int k = lo; k < hi; k++)
            if (ent_col[k] == w.column) acc = longint'(ent_val[k]) * 65536;
        end
        res.out_row = w.row[5:0];
        res.sum     = acc;
        res.last    = 1'b1;
        pending_sums.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic in_word_t random_word(input logic [2:0] op);
    in_word_t w;
    w.op      = op;
    w.slot    = $urandom_range(0, N_SLOTS - 1);
    w.row     = $urandom_range(0, 127);
    w.column  = $urandom_range(0, N_ROWS - 1);
    w.value   = $urandom;
    w.pointer = $urandom_range(0, 2047);
    return w;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input in_word_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    csr_apply(w);
  endtask

  task automatic send_pointer(input int r, input int p);
    in_word_t w;
    w = random_word(OP_ROW_PTR);
    w.row     = r;
    w.pointer = p;
    send_word(w);
    items_sent++;
  endtask

  task automatic send_entry(input int slot, input int col, input logic [31:0] val);
    in_word_t w;
    w = random_word(OP_ENTRY);
    w.slot   = slot;
    w.column = col;
    w.value  = val;
    send_word(w);
    items_sent++;
  endtask

  task automatic send_vector(input int col, input logic [31:0] val);
    in_word_t w;
    w = random_word(OP_VECTOR);
    w.column = col;
    w.value  = val;
    send_word(w);
    items_sent++;
  endtask

  task automatic send_multiply();
    send_word(random_word(OP_MULTIPLY));
    items_sent++;
  endtask

  task automatic send_get(input int r, input int col);
    in_word_t w;
    w = random_word(OP_GET);
    w.row    = r;
    w.column = col;
    send_word(w);
    items_sent++;
  endtask

  task automatic maybe_noise();
    in_word_t w;
    if ($urandom_range(0, 9) == 0) begin
      w = random_word(OP_ROW_PTR);
      if ($urandom_range(0, 1) == 0) w.op = OP_FIRST_UNUSED + $urandom_range(0, 2);
      else w.row = $urandom_range(N_ROWS + 1, 127);
      send_word(w);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_row_count(input logic [6:0] count);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we   <= 1'b0;
    rows_cfg = count;
  endtask

  task automatic run_matrix_sequence(input int n_rows, input logic [6:0] count, input bit hold);
    int          base;
    int          cur;
    int          r;
    int          col;
    int          lo;
    int          hi;
    bit          ready;
    logic [10:0] starts [0:N_ROWS];
    set_row_count(count);
    base = $urandom_range(0, N_SLOTS - 4 * n_rows);
    cur  = base;
    for (r = 0; r <= n_rows; r++) begin
      starts[r] = cur;
      if (r < n_rows) cur += $urandom_range(0, 4);
    end
    // break one row boundary: the row before goes empty, the row after widens
    if (n_rows > 1 && $urandom_range(0, 3) == 0) begin
      r = $urandom_range(1, n_rows - 1);
      starts[r] = $urandom_range(base, starts[r - 1]);
    end
    for (r = 0; r <= n_rows; r++) begin
      maybe_noise();
      send_pointer(r, starts[r]);
    end
    for (col = 0; col < n_rows; col++) send_vector(col, pick_value());
    for (int k = base; k < cur; k++) begin
      maybe_noise();
      col = ($urandom_range(0, 7) == 0) ? $urandom_range(0, N_ROWS - 1)
                                        : $urandom_range(0, n_rows - 1);
      if (!vec_known[col]) send_vector(col, pick_value());
      send_entry(k, col, pick_value());
    end
    ready = 1'b1;
    for (r = 0; r < active_rows(); r++) ready &= row_readable(r, 1'b1);
    if (ready) begin
      if (hold) hold_req = 1'b1;
      send_multiply();
    end
    if (!hold && $urandom_range(0, 3) == 0) wait_idle();
    repeat ($urandom_range(2, 6)) begin
      r   = ($urandom_range(0, 5) == 0) ? $urandom_range(N_ROWS, 127)
                                        : $urandom_range(0, n_rows - 1);
      col = $urandom_range(0, N_ROWS - 1);
      if (r >= N_ROWS) begin
        send_get(r, col);
      end else if (row_readable(r, 1'b0)) begin
        lo = clamp_ptr(row_ptr[r]);
        hi = clamp_ptr(row_ptr[r + 1]);
        if (hi > lo && $urandom_range(0, 2) != 0) col = ent_col[$urandom_range(lo, hi - 1)];
        send_get(r, col);
      end
    end
  endtask

  task automatic test_saturation_and_lookup();
    in_word_t w;
    set_row_count(7'd3);
    send_pointer(0, 0);
    send_pointer(1, 3);
    send_pointer(2, 7);
    send_pointer(3, 7);
    send_entry(0, 0, 32'h8000_0000);
    send_entry(1, 0, 32'h8000_0000);
    send_entry(2, 0, 32'h7FFF_FFFF);
    send_entry(3, 1, 32'h7FFF_FFFF);
    send_entry(4, 1, 32'h7FFF_FFFF);
    send_entry(5, 1, 32'h7FFF_FFFF);
    send_entry(6, 63, 32'h0001_0000);
    send_vector(0, 32'h8000_0000);
    send_vector(1, 32'h8000_0000);
    send_vector(63, 32'h7FFF_FFFF);
    send_multiply();
    send_get(0, 0);
    send_get(1, 63);
    send_get(1, 5);
    send_get(2, 0);
    send_get(N_ROWS, 0);
    send_get(127, 63);
    for (int i = 0; i < 3; i++) begin
      w = random_word(OP_FIRST_UNUSED + i);
      send_word(w);
    end
    w = random_word(OP_ROW_PTR);
    w.row     = N_ROWS + 1;
    w.pointer = 11'h7FF;
    send_word(w);
    w.row = 7'h7F;
    send_word(w);
    send_get(0, 0);
  endtask

  task automatic test_row_bound_clamps();
    send_pointer(0, 1020);
    send_pointer(1, 2047);
    send_pointer(2, 1500);
    send_pointer(3, 5);
    send_entry(1020, 0, 32'h0000_0001);
    send_entry(1021, 1, 32'hFFFF_FFFF);
    send_entry(1022, 63, 32'h7FFF_FFFF);
    send_entry(1023, 0, 32'h8000_0000);
    send_multiply();
    send_get(0, 0);
    send_get(1, 0);
    set_row_count(7'd0);
    send_multiply();
    set_row_count(7'd1);
    send_multiply();
  endtask

  task automatic test_result_backpressure();
    run_matrix_sequence(16, 7'd16, 1'b1);
  endtask

  task automatic test_random_matrices();
    int         n;
    logic [6:0] count;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: n = N_ROWS;
        1: n = 1;
        default: n = $urandom_range(2, 10);
      endcase
      count = n;
      if ($urandom_range(0, 2) == 0)
        count = (n == N_ROWS) ? $urandom_range(N_ROWS + 1, 127) : $urandom_range(1, n);
      run_matrix_sequence(n, count, 1'b0);
    end
  endtask

  task automatic test_unbroken_flow();
    calm = 1'b1;
    run_matrix_sequence(1, 7'd1, 1'b0);
    run_matrix_sequence(N_ROWS, 7'd127, 1'b0);
    run_matrix_sequence(4, 7'd4, 1'b0);
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual row %0d sum %h last %b",
                 $time, out_word.out_row, out_word.sum, out_word.last);
      end else begin
        want = pending_sums.pop_front();
        if (out_word.out_row !== want.out_row) begin
          errors++;
          $display("%0t: out_row mismatch, expected %0d, actual %0d",
                   $time, want.out_row, out_word.out_row);
        end
        if (out_word.sum !== want.sum) begin
          errors++;
          $display("%0t: sum mismatch on row %0d, expected %h, actual %h",
                   $time, want.out_row, want.sum, out_word.sum);
        end
        if (out_word.last !== want.last) begin
          errors++;
          $display("%0t: last mismatch on row %0d, expected %b, actual %b",
                   $time, want.out_row, want.last, out_word.last);
        end
      end
    end
  end

  initial begin : result_stall
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (calm || stall_left == 0) begin
        out_stall <= 1'b0;
        if (run_left > 0) begin
          run_left--;
        end else begin
          stall_left = $urandom_range(1, GAP_MAX);
          run_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(0, 20);
        end
      end else begin
        out_stall <= 1'b1;
        stall_left--;
      end
    end
  end

  initial begin : watchdog
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    errors     = 0;
    items_sent = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    rows_cfg   = ROW_COUNT_RESET;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_saturation_and_lookup();
    test_row_bound_clamps();
    test_result_backpressure();
    test_random_matrices();
    test_unbroken_flow();
    wait_idle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
